@@ sv/ssc_pkg.sv @@
`default_nettype none

package ssc_pkg;

	// screen coordinates of the face, signed so parts can sit left of or above the screen
	localparam int unsigned PW = 13;
	typedef logic signed [PW-1:0] pos_t;

	typedef logic [6:0] seg_t;

	localparam int unsigned SEG_A = 0;
	localparam int unsigned SEG_B = 1;
	localparam int unsigned SEG_C = 2;
	localparam int unsigned SEG_D = 3;
	localparam int unsigned SEG_E = 4;
	localparam int unsigned SEG_F = 5;
	localparam int unsigned SEG_G = 6;

	localparam int unsigned DW_W = 9;

	typedef enum logic [2:0] {
		REG_SCREEN_WIDTH  = 3'd0,
		REG_SCREEN_HEIGHT = 3'd1,
		REG_CLOCK_HOUR    = 3'd2,
		REG_CLOCK_MINUTE  = 3'd3,
		REG_TWELVE_HOUR   = 3'd4,
		REG_TOP_PLACEMENT = 3'd5,
		REG_TIME_VALID    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic       two;
		logic [1:0] tens;
		logic [3:0] ones;
	} hour_t;

	typedef struct packed {
		logic [2:0] tens;
		logic [3:0] ones;
	} minute_t;

	// face geometry: screen positions, then offsets from a digit's top left corner
	typedef struct packed {
		pos_t [3:0] p;
		pos_t       pc;
		pos_t       ytop;
		pos_t       h;
		pos_t       hg;
		pos_t       x1;
		pos_t       rr;
		pos_t       bb;
		pos_t       dw;
		pos_t       fy1;
		pos_t       ey0;
		pos_t       ey1;
		pos_t       dot;
		pos_t       cy0;
		pos_t       cy0e;
		pos_t       cy1;
		pos_t       cy1e;
		seg_t [3:0] seg;
	} face_t;

	// exact floor(x/5) for x below 2560
	function automatic logic [DW_W-1:0] div5(input logic [11:0] x);
		logic [24:0] prod;
		prod = 25'(x) * 25'd6554;
		return prod[23:15];
	endfunction

	// exact floor(x/3) for x below 512
	function automatic logic [8:0] div3(input logic [8:0] x);
		logic [19:0] prod;
		prod = 20'(x) * 20'd683;
		return prod[19:11];
	endfunction

	// halve, rounding toward zero
	function automatic pos_t half_tz(input pos_t v);
		pos_t a;
		a = v + pos_t'(v[PW-1]);
		return a >>> 1;
	endfunction

	function automatic seg_t digit_seg(input logic [3:0] d);
		seg_t s;
		unique case (d)
			4'd0: s = 7'h3F;
			4'd1: s = 7'h06;
			4'd2: s = 7'h5B;
			4'd3: s = 7'h4F;
			4'd4: s = 7'h66;
			4'd5: s = 7'h6D;
			4'd6: s = 7'h7D;
			4'd7: s = 7'h07;
			4'd8: s = 7'h7F;
			4'd9: s = 7'h6F;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

	function automatic hour_t split_hour(input logic [4:0] hr, input logic twelve);
		logic [4:0] h;
		hour_t r;
		h = hr;
		if (twelve) begin
			if (hr >= 5'd24) h = hr - 5'd24;
			else if (hr >= 5'd12) h = hr - 5'd12;
			if (h == 5'd0) h = 5'd12;
		end
		if (h >= 5'd30) r.tens = 2'd3;
		else if (h >= 5'd20) r.tens = 2'd2;
		else if (h >= 5'd10) r.tens = 2'd1;
		else r.tens = 2'd0;
		r.ones = 4'(h - 5'(r.tens) * 5'd10);
		r.two = !twelve || (h >= 5'd10);
		return r;
	endfunction

	function automatic minute_t split_minute(input logic [5:0] mn);
		minute_t r;
		r.tens = 3'd0;
		for (int k = 1; k <= 6; k++) begin
			if (mn >= 6'(10 * k)) r.tens = 3'(k);
		end
		r.ones = 4'(mn - 6'(r.tens) * 6'd10);
		return r;
	endfunction

endpackage

`default_nettype wire

@@ sv/seven_segment_clock_rasterizer_core.sv @@
`default_nettype none

// channel   | handshake              | beat
// ----------+------------------------+-------------------------
// pixel in  | pix_valid / pix_ready  | pixel_x, pixel_y
// result    | res_valid / res_ready  | lit
// config    | apb psel/penable/...   | 7 registers at 4*index
//
// one pixel per cycle while pix_ready is high, seven register stages from pixel in to res_valid
// face geometry comes from a four-level register chain behind the config registers
// pix_ready is low after reset and during and after each register write while that chain fills
// a stalled stage holds its beat, earlier stages keep filling bubbles

module seven_segment_clock_rasterizer_core
	import ssc_pkg::*;
#(
	parameter int COORD_WIDTH = 11
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pix_valid,
	output logic                   pix_ready,
	input  logic [COORD_WIDTH-1:0] pixel_x,
	input  logic [COORD_WIDTH-1:0] pixel_y,
	output logic                   res_valid,
	input  logic                   res_ready,
	output logic                   lit,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [4:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	localparam int SW = (COORD_WIDTH > 12 ? COORD_WIDTH : 12) + 2;
	localparam logic [2:0] WARM_CYCLES = 3'd4;

	typedef logic signed [SW-1:0] crd_t;

	function automatic crd_t mag(input crd_t v);
		return v[SW-1] ? -v : v;
	endfunction

	// configuration registers
	logic [10:0] screen_width_q;
	logic [10:0] screen_height_q;
	logic [4:0]  clock_hour_q;
	logic [5:0]  clock_minute_q;
	logic        twelve_hour_q;
	logic        top_placement_q;
	logic        time_valid_q;
	reg_idx_t    reg_idx;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q <= 11'd480;
			screen_height_q <= 11'd800;
			clock_hour_q <= 5'd0;
			clock_minute_q <= 6'd0;
			twelve_hour_q <= 1'b0;
			top_placement_q <= 1'b0;
			time_valid_q <= 1'b1;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SCREEN_WIDTH:  screen_width_q <= pwdata[10:0];
				REG_SCREEN_HEIGHT: screen_height_q <= pwdata[10:0];
				REG_CLOCK_HOUR:    clock_hour_q <= pwdata[4:0];
				REG_CLOCK_MINUTE:  clock_minute_q <= pwdata[5:0];
				REG_TWELVE_HOUR:   twelve_hour_q <= pwdata[0];
				REG_TOP_PLACEMENT: top_placement_q <= pwdata[0];
				REG_TIME_VALID:    time_valid_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SCREEN_WIDTH:  prdata = 32'(screen_width_q);
			REG_SCREEN_HEIGHT: prdata = 32'(screen_height_q);
			REG_CLOCK_HOUR:    prdata = 32'(clock_hour_q);
			REG_CLOCK_MINUTE:  prdata = 32'(clock_minute_q);
			REG_TWELVE_HOUR:   prdata = 32'(twelve_hour_q);
			REG_TOP_PLACEMENT: prdata = 32'(top_placement_q);
			REG_TIME_VALID:    prdata = 32'(time_valid_q);
			default:           prdata = 32'd0;
		endcase
	end

	face_t face;

	ssc_metrics u_metrics (
		.clk              (clk),
		.screen_width     (screen_width_q),
		.screen_height    (screen_height_q),
		.clock_hour       (clock_hour_q),
		.clock_minute     (clock_minute_q),
		.twelve_hour_mode (twelve_hour_q),
		.top_placement    (top_placement_q),
		.time_valid       (time_valid_q),
		.face             (face)
	);

	// hold off input until the geometry chain holds the current register values
	logic [2:0] warm_q;
	logic       warm_done;

	assign warm_done = (warm_q == WARM_CYCLES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= 3'd0;
		end else if (cfg_wr) begin
			warm_q <= 3'd0;
		end else if (!warm_done) begin
			warm_q <= warm_q + 3'd1;
		end
	end

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;
	logic acc;

	assign en7 = !v_s7 || res_ready;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign pix_ready = en1 && warm_done && !cfg_wr;
	assign acc = pix_valid && pix_ready;
	assign res_valid = v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= acc;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	// stages 1 to 4: capture, clip test, align with the geometry chain
	logic [COORD_WIDTH-1:0] px_s1, py_s1, px_s2, py_s2, px_s3, py_s3, px_s4, py_s4;
	logic on_s2, on_s3, on_s4, on_s5, on_s6;

	always_ff @(posedge clk) begin
		if (en1) begin
			px_s1 <= pixel_x;
			py_s1 <= pixel_y;
		end
		if (en2) begin
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			on_s2 <= (crd_t'(px_s1) < crd_t'(screen_width_q)) &&
				(crd_t'(py_s1) < crd_t'(screen_height_q));
		end
		if (en3) begin
			px_s3 <= px_s2;
			py_s3 <= py_s2;
			on_s3 <= on_s2;
		end
		if (en4) begin
			px_s4 <= px_s3;
			py_s4 <= py_s3;
			on_s4 <= on_s3;
		end
	end

	// stage 5: coordinates relative to each digit and the colon
	crd_t rx_s5 [4];
	crd_t rxc_s5;
	crd_t ry_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			for (int i = 0; i < 4; i++) begin
				rx_s5[i] <= crd_t'(px_s4) - crd_t'(face.p[i]);
			end
			rxc_s5 <= crd_t'(px_s4) - crd_t'(face.pc);
			ry_s5 <= crd_t'(py_s4) - crd_t'(face.ytop);
			on_s5 <= on_s4;
		end
	end

	// stage 6: distances from bar center lines, colon dots
	crd_t da_s6, dg_s6, dd_s6, ry_s6;
	crd_t rx_s6 [4];
	crd_t dl_s6 [4];
	crd_t dr_s6 [4];
	logic colon_s6;
	logic colon_d;

	always_comb begin
		colon_d = (rxc_s5 >= crd_t'(0)) && (rxc_s5 < crd_t'(face.dot)) &&
			(((ry_s5 >= crd_t'(face.cy0)) && (ry_s5 < crd_t'(face.cy0e))) ||
			((ry_s5 >= crd_t'(face.cy1)) && (ry_s5 < crd_t'(face.cy1e))));
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			da_s6 <= mag(ry_s5 - crd_t'(face.h));
			dg_s6 <= mag(ry_s5 - crd_t'(face.dw));
			dd_s6 <= mag(ry_s5 - crd_t'(face.bb));
			for (int i = 0; i < 4; i++) begin
				dl_s6[i] <= mag(rx_s5[i] - crd_t'(face.h));
				dr_s6[i] <= mag(rx_s5[i] - crd_t'(face.rr));
				rx_s6[i] <= rx_s5[i];
			end
			ry_s6 <= ry_s5;
			colon_s6 <= colon_d;
			on_s6 <= on_s5;
		end
	end

	// stage 7: bar tests with pointed tips, result register
	logic lit_d;
	logic lit_s7;
	crd_t eh, ehg, ex1, efy1, eey0, eey1;

	always_comb begin
		eh = crd_t'(face.h);
		ehg = crd_t'(face.hg);
		ex1 = crd_t'(face.x1);
		efy1 = crd_t'(face.fy1);
		eey0 = crd_t'(face.ey0);
		eey1 = crd_t'(face.ey1);
		lit_d = colon_s6;
		for (int i = 0; i < 4; i++) begin
			if (face.seg[i][SEG_A] && (da_s6 <= eh) &&
				(rx_s6[i] >= ehg + da_s6) && (rx_s6[i] <= ex1 - da_s6)) lit_d = 1'b1;
			if (face.seg[i][SEG_G] && (dg_s6 <= eh) &&
				(rx_s6[i] >= ehg + dg_s6) && (rx_s6[i] <= ex1 - dg_s6)) lit_d = 1'b1;
			if (face.seg[i][SEG_D] && (dd_s6 <= eh) &&
				(rx_s6[i] >= ehg + dd_s6) && (rx_s6[i] <= ex1 - dd_s6)) lit_d = 1'b1;
			if (face.seg[i][SEG_F] && (dl_s6[i] <= eh) &&
				(ry_s6 >= ehg + dl_s6[i]) && (ry_s6 <= efy1 - dl_s6[i])) lit_d = 1'b1;
			if (face.seg[i][SEG_B] && (dr_s6[i] <= eh) &&
				(ry_s6 >= ehg + dr_s6[i]) && (ry_s6 <= efy1 - dr_s6[i])) lit_d = 1'b1;
			if (face.seg[i][SEG_E] && (dl_s6[i] <= eh) &&
				(ry_s6 >= eey0 + dl_s6[i]) && (ry_s6 <= eey1 - dl_s6[i])) lit_d = 1'b1;
			if (face.seg[i][SEG_C] && (dr_s6[i] <= eh) &&
				(ry_s6 >= eey0 + dr_s6[i]) && (ry_s6 <= eey1 - dr_s6[i])) lit_d = 1'b1;
		end
		lit_d = lit_d && on_s6;
	end

	always_ff @(posedge clk) begin
		if (en7) begin
			lit_s7 <= lit_d;
		end
	end

	assign lit = lit_s7;

	// clipped pixels come out dark
	a_clip_dark: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && en7 && !on_s6 |=> !lit)
		else $error("clipped pixel reported lit");

	// nothing enters before the geometry chain is filled
	a_warm: assert property (@(posedge clk) disable iff (!arst_n)
		!warm_done |-> !v_s1)
		else $error("beat accepted during warm-up");

	// tip gap of at least one pixel
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		warm_done |-> face.hg > face.h)
		else $error("segment gap is zero");

	// a stalled stage keeps its beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && !en7 |=> v_s6 && $stable(on_s6) && $stable(colon_s6))
		else $error("stalled stage lost its beat");

endmodule

`default_nettype wire

@@ sv/ssc_metrics.sv @@
`default_nettype none

// free-running four-level chain from the register values to the face geometry
module ssc_metrics
	import ssc_pkg::*;
(
	input  logic        clk,
	input  logic [10:0] screen_width,
	input  logic [10:0] screen_height,
	input  logic [4:0]  clock_hour,
	input  logic [5:0]  clock_minute,
	input  logic        twelve_hour_mode,
	input  logic        top_placement,
	input  logic        time_valid,
	output face_t       face
);

	// level 1
	logic [DW_W-1:0] dw_q;
	logic [8:0]      h12_q;
	hour_t           hour_q;
	minute_t         minute_q;
	logic            unset_q;
	logic            top_q;
	logic [11:0]     inner_w;

	assign inner_w = 12'(screen_width) - 12'({screen_width[10:4], 1'b0});

	always_ff @(posedge clk) begin
		dw_q <= div5(inner_w);
		h12_q <= div3(9'(screen_height[10:2]));
		hour_q <= split_hour(clock_hour, twelve_hour_mode);
		minute_q <= split_minute(clock_minute);
		unset_q <= !time_valid;
		top_q <= top_placement;
	end

	// level 2
	logic [DW_W-1:0] dw2_q;
	logic [5:0]      h2_q;
	logic [3:0]      g2_q;
	logic [6:0]      pg2_q;
	logic [7:0]      cw2_q;
	logic [7:0]      off2_q;
	logic [8:0]      h12_2_q;
	hour_t           hour2_q;
	minute_t         minute2_q;
	logic            unset2_q;
	logic            top2_q;
	logic [3:0]      g_raw;

	assign g_raw = 4'(div5(12'(dw_q >> 3)));

	always_ff @(posedge clk) begin
		dw2_q <= dw_q;
		h2_q <= 6'(dw_q >> 3);
		g2_q <= (g_raw == 4'd0) ? 4'd1 : g_raw;
		pg2_q <= 7'(div5(12'(dw_q)));
		cw2_q <= 8'(div5(12'(dw_q) * 12'd3));
		off2_q <= 8'(div5(12'({dw_q, 1'b0})));
		h12_2_q <= h12_q;
		hour2_q <= hour_q;
		minute2_q <= minute_q;
		unset2_q <= unset_q;
		top2_q <= top_q;
	end

	// level 3
	face_t f3;
	face_t face3_q;
	pos_t  fw3_q;
	pos_t  dw_e, h_e, g_e, pg_e, cw_e, off_e, dot_e, dxoff, fw, o1;
	logic  two;
	seg_t  dash;

	always_comb begin
		dw_e = pos_t'(dw2_q);
		h_e = pos_t'(h2_q);
		g_e = pos_t'(g2_q);
		pg_e = pos_t'(pg2_q);
		cw_e = pos_t'(cw2_q);
		off_e = pos_t'(off2_q);
		dot_e = pos_t'({h2_q, 1'b1});
		dxoff = half_tz(cw_e - dot_e);
		two = unset2_q || hour2_q.two;
		dash = seg_t'(1) << SEG_G;
		fw = two ? (dw_e + dw_e + dw_e + dw_e + pg_e + pg_e + cw_e)
			: (dw_e + dw_e + dw_e + pg_e + cw_e);
		o1 = two ? (dw_e + pg_e) : pos_t'(0);

		f3.p[0] = pos_t'(0);
		f3.p[1] = o1;
		f3.p[2] = o1 + dw_e + cw_e;
		f3.p[3] = o1 + dw_e + cw_e + dw_e + pg_e;
		f3.pc = o1 + dw_e + dxoff;
		f3.ytop = (!unset2_q && top2_q) ? pos_t'(h12_2_q)
			: half_tz(pos_t'(screen_height) - dw_e - dw_e);
		f3.h = h_e;
		f3.hg = h_e + g_e;
		f3.x1 = dw_e - pos_t'(1) - h_e - g_e;
		f3.rr = dw_e - pos_t'(1) - h_e;
		f3.bb = dw_e + dw_e - pos_t'(1) - h_e;
		f3.dw = dw_e;
		f3.fy1 = dw_e - g_e;
		f3.ey0 = dw_e + g_e;
		f3.ey1 = dw_e + dw_e - pos_t'(1) - h_e - g_e;
		f3.dot = dot_e;
		f3.cy0 = dw_e - off_e - h_e;
		f3.cy0e = dw_e - off_e - h_e + dot_e;
		f3.cy1 = dw_e + off_e - h_e;
		f3.cy1e = dw_e + off_e - h_e + dot_e;
		if (unset2_q) begin
			f3.seg = {dash, dash, dash, dash};
		end else begin
			f3.seg[0] = hour2_q.two ? digit_seg(4'(hour2_q.tens)) : seg_t'(0);
			f3.seg[1] = digit_seg(hour2_q.ones);
			f3.seg[2] = digit_seg(4'(minute2_q.tens));
			f3.seg[3] = digit_seg(minute2_q.ones);
		end
	end

	always_ff @(posedge clk) begin
		face3_q <= f3;
		fw3_q <= fw;
	end

	// level 4: place the digits on the screen
	face_t face_q;
	face_t face_n;
	pos_t  x0;

	assign x0 = half_tz(pos_t'(screen_width) - fw3_q);

	always_comb begin
		face_n = face3_q;
		for (int i = 0; i < 4; i++) begin
			face_n.p[i] = x0 + face3_q.p[i];
		end
		face_n.pc = x0 + face3_q.pc;
	end

	always_ff @(posedge clk) begin
		face_q <= face_n;
	end

	assign face = face_q;

endmodule

`default_nettype wire

@@ verif/seven_segment_clock_rasterizer_core_tb.sv @@
`timescale 1ns / 1ps

module seven_segment_clock_rasterizer_core_tb;
	import ssc_pkg::*;

	typedef struct {
		int unsigned width;
		int unsigned height;
		int unsigned hour;
		int unsigned minute;
		bit          twelve;
		bit          top;
		bit          valid;
	} face_cfg_t;

	typedef struct {
		logic [10:0] x;
		logic [10:0] y;
	} pixel_t;

	localparam int CYCLE_LIMIT = 600000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        pix_valid = 1'b0;
	logic        pix_ready;
	logic [10:0] pixel_x = '0;
	logic [10:0] pixel_y = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic        lit;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	face_cfg_t   face;
	pixel_t      pixel_fifo[$];
	bit          lit_expected[$];
	int          send_gap_max = 0;
	int          recv_stall_max = 0;
	bit          hold_send = 1'b0;
	int          send_gap = 0;
	int          recv_stall = 0;
	int          mismatches = 0;
	int          beats_checked = 0;
	int          lit_seen = 0;
	int          cycles = 0;

	const logic [6:0] seg_of_digit[10] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
		7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};

	seven_segment_clock_rasterizer_core #(.COORD_WIDTH(11)) dut (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_ready(pix_ready),
		.pixel_x(pixel_x), .pixel_y(pixel_y),
		.res_valid(res_valid), .res_ready(res_ready), .lit(lit),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	function automatic bit on_hbar(int x0, int x1, int yc, int h, int px, int py);
		int d;
		d = py > yc ? py - yc : yc - py;
		return d <= h && px >= x0 + d && px <= x1 - d;
	endfunction

	function automatic bit on_vbar(int xc, int y0, int y1, int h, int px, int py);
		int d;
		d = px > xc ? px - xc : xc - px;
		return d <= h && py >= y0 + d && py <= y1 - d;
	endfunction

	function automatic bit on_digit(int dw, int h, int g, int x, int y, logic [6:0] s,
			int px, int py);
		int l, r, t, m, b;
		l = x + h;
		r = x + dw - 1 - h;
		t = y + h;
		m = y + dw;
		b = y + 2 * dw - 1 - h;
		return (s[SEG_A] && on_hbar(l + g, r - g, t, h, px, py)) ||
			(s[SEG_G] && on_hbar(l + g, r - g, m, h, px, py)) ||
			(s[SEG_D] && on_hbar(l + g, r - g, b, h, px, py)) ||
			(s[SEG_F] && on_vbar(l, t + g, m - g, h, px, py)) ||
			(s[SEG_B] && on_vbar(r, t + g, m - g, h, px, py)) ||
			(s[SEG_E] && on_vbar(l, m + g, b - g, h, px, py)) ||
			(s[SEG_C] && on_vbar(r, m + g, b - g, h, px, py));
	endfunction

	function automatic bit on_colon(int dw, int h, int cw, int x, int y, int px, int py);
		int dot, dx, m, off;
		dot = 2 * h + 1;
		dx = x + (cw - dot) / 2;
		m = y + dw;
		off = (2 * dw) / 5;
		return (px >= dx && px < dx + dot) &&
			((py >= m - off - h && py < m - off - h + dot) ||
			 (py >= m + off - h && py < m + off - h + dot));
	endfunction

	function automatic bit pixel_lit(face_cfg_t c, int px, int py);
		int w, hgt, dw, h, g, pg, cw, pw, x, y, fw, hr;
		bit two, hit;
		w = c.width;
		hgt = c.height;
		dw = (w - 2 * (w / 16)) / 5;
		h = dw / 8;
		g = dw / 40 < 1 ? 1 : dw / 40;
		pg = dw / 5;
		cw = dw * 3 / 5;
		hit = 1'b0;
		if (px >= w || py >= hgt) return 1'b0;
		if (!c.valid) begin
			pw = 2 * dw + pg;
			x = (w - (2 * pw + cw)) / 2;
			y = (hgt - 2 * dw) / 2;
			return on_digit(dw, h, g, x, y, 7'h40, px, py) ||
				on_digit(dw, h, g, x + dw + pg, y, 7'h40, px, py) ||
				on_colon(dw, h, cw, x + pw, y, px, py) ||
				on_digit(dw, h, g, x + pw + cw, y, 7'h40, px, py) ||
				on_digit(dw, h, g, x + pw + cw + dw + pg, y, 7'h40, px, py);
		end
		hr = c.hour;
		if (c.twelve) begin
			hr = hr % 12;
			if (hr == 0) hr = 12;
		end
		two = !c.twelve || hr >= 10;
		fw = (two ? 2 * dw + pg : dw) + cw + 2 * dw + pg;
		x = (w - fw) / 2;
		y = c.top ? hgt / 12 : (hgt - 2 * dw) / 2;
		if (two) begin
			hit |= on_digit(dw, h, g, x, y, seg_of_digit[(hr / 10) % 10], px, py);
			x += dw + pg;
		end
		hit |= on_digit(dw, h, g, x, y, seg_of_digit[hr % 10], px, py);
		x += dw;
		hit |= on_colon(dw, h, cw, x, y, px, py);
		x += cw;
		hit |= on_digit(dw, h, g, x, y, seg_of_digit[c.minute / 10], px, py);
		x += dw + pg;
		hit |= on_digit(dw, h, g, x, y, seg_of_digit[c.minute % 10], px, py);
		return hit;
	endfunction

	task automatic report_mismatch(bit got, bit want, string why);
		mismatches++;
		$display("MISMATCH t=%0t %s: lit got %0b want %0b", $realtime, why, got, want);
	endtask

	// pixel driver
	always @(posedge clk) begin
		pixel_t p;
		if (pix_valid && pix_ready)
			lit_expected.push_back(pixel_lit(face, pixel_x, pixel_y));
		if (!pix_valid || pix_ready) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				pix_valid <= 1'b0;
			end else if (pixel_fifo.size() > 0 && !hold_send) begin
				p = pixel_fifo.pop_front();
				pixel_x <= p.x;
				pixel_y <= p.y;
				pix_valid <= 1'b1;
				send_gap <= $urandom_range(0, send_gap_max);
			end else begin
				pix_valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		bit want;
		int stall;
		stall = recv_stall;
		if (res_valid && res_ready) begin
			beats_checked++;
			if (lit) lit_seen++;
			if (lit_expected.size() == 0) begin
				report_mismatch(lit, 1'b0, "beat with nothing expected");
			end else begin
				want = lit_expected.pop_front();
				if (lit !== want) report_mismatch(lit, want, "wrong pixel value");
			end
			stall = $urandom_range(0, recv_stall_max);
		end
		if (stall > 0) begin
			res_ready <= 1'b0;
			recv_stall <= stall - 1;
		end else begin
			res_ready <= 1'b1;
			recv_stall <= 0;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic apb_write(reg_idx_t idx, int unsigned value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(4 * idx);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pixel_fifo.size() > 0 || pix_valid || lit_expected.size() > 0)
			@(negedge clk);
	endtask

	task automatic load_face(face_cfg_t c);
		wait_drained();
		repeat (10) @(posedge clk);
		apb_write(REG_SCREEN_WIDTH, c.width);
		apb_write(REG_SCREEN_HEIGHT, c.height);
		apb_write(REG_CLOCK_HOUR, c.hour);
		apb_write(REG_CLOCK_MINUTE, c.minute);
		apb_write(REG_TWELVE_HOUR, c.twelve);
		apb_write(REG_TOP_PLACEMENT, c.top);
		apb_write(REG_TIME_VALID, c.valid);
		// let the geometry chain behind the registers settle
		repeat (10) @(posedge clk);
		@(negedge clk);
		face = c;
	endtask

	task automatic push_pixel(int x, int y);
		pixel_t p;
		p.x = 11'(x);
		p.y = 11'(y);
		pixel_fifo.push_back(p);
	endtask

	// mostly aim at the face area, some anywhere
	task automatic push_face_pixels(int n);
		int dw, fy, x, y;
		dw = (face.width - 2 * (face.width / 16)) / 5;
		fy = (face.top && face.valid) ? int'(face.height / 12)
			: (int'(face.height) - 2 * dw) / 2;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 9) < 7) begin
				x = $urandom_range(0, face.width + 4);
				y = fy + int'($urandom_range(0, 2 * dw + 6)) - 3;
				if (y < 0) y = $urandom_range(0, 3);
				if (x > 2047) x = 2047;
				if (y > 2047) y = 2047;
			end else begin
				x = $urandom_range(0, 2047);
				y = $urandom_range(0, 2047);
			end
			push_pixel(x, y);
		end
	endtask

	initial begin
		face_cfg_t c;
		face_cfg_t fixed[$];
		int dw, fy;
		face = '{480, 800, 0, 0, 1'b0, 1'b0, 1'b1};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset face: corners, off-screen and a sweep along the middle row
		dw = (480 - 2 * 30) / 5;
		fy = (800 - 2 * dw) / 2;
		push_pixel(0, 0);
		push_pixel(2047, 2047);
		push_pixel(479, 799);
		push_pixel(480, fy + dw);
		push_pixel(100, 800);
		push_pixel(2047, 0);
		push_pixel(0, 2047);
		for (int k = 0; k < 16; k++) push_pixel(40 + 26 * k, fy + dw);

		fixed.push_back('{16, 16, 23, 59, 1'b0, 1'b0, 1'b1});
		fixed.push_back('{2047, 2047, 12, 0, 1'b1, 1'b1, 1'b1});
		fixed.push_back('{2047, 2047, 9, 7, 1'b1, 1'b0, 1'b1});
		fixed.push_back('{480, 800, 0, 0, 1'b0, 1'b0, 1'b0});
		fixed.push_back('{600, 40, 0, 0, 1'b0, 1'b0, 1'b0});
		fixed.push_back('{800, 30, 31, 63, 1'b0, 1'b1, 1'b1});
		fixed.push_back('{480, 800, 31, 63, 1'b1, 1'b0, 1'b1});
		fixed.push_back('{5, 0, 18, 45, 1'b1, 1'b0, 1'b1});
		fixed.push_back('{0, 2047, 11, 8, 1'b0, 1'b1, 1'b0});
		fixed.push_back('{1200, 1600, 24, 30, 1'b1, 1'b1, 1'b1});

		for (int ph = 0; ph < 27; ph++) begin
			if (ph < fixed.size()) begin
				c = fixed[ph];
			end else begin
				c.width = $urandom_range(0, 9) == 0 ? $urandom_range(0, 15)
					: $urandom_range(16, 2047);
				c.height = $urandom_range(0, 9) == 0 ? $urandom_range(0, 63)
					: $urandom_range(16, 2047);
				c.hour = $urandom_range(0, 31);
				c.minute = $urandom_range(0, 63);
				c.twelve = $urandom_range(0, 1);
				c.top = $urandom_range(0, 1);
				c.valid = $urandom_range(0, 4) != 0;
			end
			case (ph % 4)
				0: begin send_gap_max = 0; recv_stall_max = 0; end
				1: begin send_gap_max = 11; recv_stall_max = 11; end
				2: begin send_gap_max = 0; recv_stall_max = 11; end
				default: begin send_gap_max = 11; recv_stall_max = 0; end
			endcase
			load_face(c);
			push_face_pixels(27);
			if (ph == 5) begin
				// stop sending until the pipeline has emptied completely
				wait_drained();
				hold_send = 1'b1;
				push_face_pixels(10);
				while (lit_expected.size() > 0 || pix_valid) @(negedge clk);
				hold_send = 1'b0;
			end
			push_face_pixels(27);
		end

		wait_drained();
		repeat (20) @(posedge clk);
		$display("covered %0d pixel beats (%0d lit) over 28 face settings,", beats_checked,
			lit_seen);
		$display("including unset face, 12-hour mode, top placement and extreme sizes");
		if (mismatches == 0 && lit_expected.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d beats still expected", mismatches,
				lit_expected.size());
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
